FILE: src/qrs_pkg.sv
// qrs_pkg: shared widths, codes and word types for the quorum round scoreboard.
// Used by qrs_engine, the top and the bench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

	// field widths, fixed by the interface
	localparam int SEQ_BITS      = 48;
	localparam int PROC_BITS     = 4;
	localparam int CLASS_BITS    = 3;
	localparam int VOTE_BITS     = 5;
	localparam int STEP_BITS     = 16;
	localparam int KIND_BITS     = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int NUM_PROCS_DEF = 16;

	// item kinds
	localparam logic [KIND_BITS-1:0] KIND_CMPL    = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_QUERY   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLASS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_QUORUM = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP   = 2'd2;

	// input word
	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic                  ok;
		logic [CLASS_BITS-1:0] msg_class;
		logic [PROC_BITS-1:0]  process;
		logic [SEQ_BITS-1:0]   seq;
		logic [SEQ_BITS-1:0]   restart_id;
	} qrs_item_t;

	// result word
	typedef struct packed {
		logic                  failed;
		logic                  ignored;
		logic                  counted;
		logic [PROC_BITS-1:0]  hit_process;
		logic [VOTE_BITS-1:0]  remaining;
		logic                  round_done;
		logic [SEQ_BITS-1:0]   round_id;
		logic [VOTE_BITS-1:0]  ready_count;
		logic                  restart_rejected;
	} qrs_result_t;

	// configuration registers as seen by the engine
	typedef struct packed {
		logic [CLASS_BITS-1:0] msg_class;
		logic [VOTE_BITS-1:0]  quorum;
		logic [STEP_BITS-1:0]  step;
	} qrs_cfg_t;

endpackage

`default_nettype wire

FILE: src/qrs_seq_mem.sv
// qrs_seq_mem: last-sequence table, one write port and one registered read port.
// Depends on nothing; depth and width come from the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module qrs_seq_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/qrs_engine.sv
// qrs_engine: sequencer for completions, restarts and count queries, with the
// round id and vote count. Depends on qrs_pkg; drives the ports of qrs_seq_mem.
`timescale 1ns / 1ps
`default_nettype none

module qrs_engine #(
	parameter int NUM_PROCS = qrs_pkg::NUM_PROCS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire qrs_pkg::qrs_cfg_t            cfg,
	input  wire logic                         start,
	input  wire qrs_pkg::qrs_item_t           item,
	output logic                              busy,
	output logic                              done,
	output qrs_pkg::qrs_result_t              result,
	output logic                              mem_we,
	output logic [$clog2(NUM_PROCS)-1:0]      mem_waddr,
	output logic [qrs_pkg::SEQ_BITS-1:0]      mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(NUM_PROCS)-1:0]      mem_raddr,
	input  wire logic [qrs_pkg::SEQ_BITS-1:0] mem_rdata
);

	import qrs_pkg::*;

	localparam int IDX_W = $clog2(NUM_PROCS);
	localparam int CNT_W = $clog2(NUM_PROCS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ONE  = 4'b0010,
		ST_FILL = 4'b0100,
		ST_SCAN = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      cnt_q, cnt_d;
	logic [CNT_W-1:0]      acc_q, acc_d;
	logic [SEQ_BITS-1:0]   round_q, round_d;
	logic [VOTE_BITS-1:0]  votes_q, votes_d;
	logic                  done_q, finish;
	qrs_item_t             item_q;
	logic [SEQ_BITS-1:0]   aux_q, aux_d;
	logic                  seq_hit_q;
	qrs_result_t           res_q, res_d;

	logic                  accept;
	logic                  in_range;
	logic                  cmp_live;
	logic                  in_order;
	logic [SEQ_BITS-1:0]   new_seq;
	logic                  vote;
	logic [VOTE_BITS-1:0]  votes_dec;
	logic [VOTE_BITS-1:0]  reload;
	logic                  scan_hit;
	logic [CNT_W-1:0]      scan_sum;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// completion datapath: old entry arrives from the table this cycle
	assign in_range  = 32'(item_q.process) < NUM_PROCS;
	assign cmp_live  = (item_q.msg_class == cfg.msg_class) && in_range;
	assign in_order  = ((mem_rdata + SEQ_BITS'(cfg.step)) == item_q.seq);
	assign new_seq   = in_order ? item_q.seq : '0;
	assign vote      = in_order ? seq_hit_q : (round_q == '0);
	assign votes_dec = vote ? (votes_q - VOTE_BITS'(1)) : votes_q;
	assign reload    = (cfg.quorum == '0) ? VOTE_BITS'(1) : cfg.quorum;

	// count query: aux_q holds round id minus step
	assign scan_hit = (mem_rdata == aux_q);
	assign scan_sum = acc_q + CNT_W'(scan_hit);

	// table reads: one at accept of a completion or query, then one per scan cycle but the last
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (accept) begin
			if (item.kind == KIND_CMPL) begin
				mem_re    = 1'b1;
				mem_raddr = IDX_W'(item.process);
			end else if (item.kind == KIND_QUERY) begin
				mem_re    = 1'b1;
				mem_raddr = '0;
			end
		end else if ((state_q == ST_SCAN) && (cnt_q != LAST_IDX)) begin
			mem_re    = 1'b1;
			mem_raddr = cnt_q + IDX_W'(1);
		end
	end

	// table writes: completion write-back or restart fill
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = aux_q;
		if ((state_q == ST_ONE) && (item_q.kind == KIND_CMPL) && item_q.ok && cmp_live) begin
			mem_we    = 1'b1;
			mem_waddr = IDX_W'(item_q.process);
			mem_wdata = new_seq;
		end else if (state_q == ST_FILL) begin
			mem_we = 1'b1;
		end
	end

	// operand latched at accept: fill value for restart, match value for query
	always_comb begin
		unique case (item.kind)
			KIND_RESTART: aux_d = item.restart_id - SEQ_BITS'(cfg.step);
			KIND_QUERY:   aux_d = round_q - SEQ_BITS'(cfg.step);
			default:      aux_d = '0;
		endcase
	end

	// sequencer and result assembly
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		round_d = round_q;
		votes_d = votes_q;
		finish  = 1'b0;
		res_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cnt_d = '0;
					acc_d = '0;
					if ((item.kind == KIND_RESTART) && (item.restart_id != '0)) begin
						state_d = ST_FILL;
					end else if (item.kind == KIND_QUERY) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_ONE;
					end
				end
			end
			ST_ONE: begin
				state_d = ST_IDLE;
				finish  = 1'b1;
				if (item_q.kind == KIND_CMPL) begin
					priority if (!item_q.ok) begin
						res_d.failed = 1'b1;
					end else if (!cmp_live) begin
						res_d.ignored = 1'b1;
					end else begin
						if (vote) begin
							res_d.counted     = 1'b1;
							res_d.hit_process = item_q.process;
						end
						if (votes_dec == '0) begin
							votes_d          = reload;
							round_d          = round_q + SEQ_BITS'(cfg.step);
							res_d.round_done = 1'b1;
						end else begin
							votes_d = votes_dec;
						end
					end
				end else if (item_q.kind == KIND_RESTART) begin
					// only a restart to zero lands here
					res_d.restart_rejected = 1'b1;
				end
			end
			ST_FILL: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
					round_d = item_q.restart_id;
				end else begin
					cnt_d = cnt_q + IDX_W'(1);
				end
			end
			ST_SCAN: begin
				acc_d = scan_sum;
				if (cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
					res_d.ready_count = (32'(scan_sum) > 32'd31) ? VOTE_BITS'(31)
						: VOTE_BITS'(scan_sum);
				end else begin
					cnt_d = cnt_q + IDX_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_d.remaining = votes_d;
		res_d.round_id  = round_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			acc_q   <= '0;
			round_q <= '0;
			votes_q <= VOTE_BITS'(1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			round_q <= round_d;
			votes_q <= votes_d;
			done_q  <= finish;
		end
	end

	// payload: latched input word and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= item;
			aux_q     <= aux_d;
			seq_hit_q <= (item.seq == round_q);
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/quorum_round_scoreboard_top.sv
// quorum_round_scoreboard_top: configuration registers, sequencer and table.
// Depends on qrs_pkg, qrs_seq_mem and qrs_engine.
//
//   channel  | handshake          | word            | notes
//   ---------+--------------------+-----------------+------------------------------
//   input    | start & !busy      | item (qrs_item_t)   | one word per accept
//   result   | done (one cycle)   | result (qrs_result_t)| one word per input word
//   config   | cfg_we             | cfg_index, cfg_data | write only, idle block only
//
// Completion, failed or ignored completion, refused restart, unused kind: busy in state
// ST_ONE after accept; table read at accept, write-back in ST_ONE, result registered.
// Restart: busy in ST_FILL, one table entry written per cycle until all NUM_PROCS are filled.
// Count query: busy in ST_SCAN, one table entry read per cycle until all NUM_PROCS are compared.
// Reset clears round id to zero, votes to one and registers to their defaults;
// the table is not cleared and must be filled by a restart before use.
// No back-pressure on results: done is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module quorum_round_scoreboard_top #(
	parameter int NUM_PROCS = qrs_pkg::NUM_PROCS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [qrs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [qrs_pkg::STEP_BITS-1:0]    cfg_data,
	input  wire logic                             start,
	input  wire qrs_pkg::qrs_item_t               item,
	output logic                                  busy,
	output logic                                  done,
	output qrs_pkg::qrs_result_t                  result
);

	import qrs_pkg::*;

	localparam int IDX_W = $clog2(NUM_PROCS);

	qrs_cfg_t              cfg_q;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [SEQ_BITS-1:0]   mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;
	logic [SEQ_BITS-1:0]   mem_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.msg_class <= '0;
			cfg_q.quorum    <= VOTE_BITS'(1);
			cfg_q.step      <= STEP_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLASS:  cfg_q.msg_class <= cfg_data[CLASS_BITS-1:0];
				CFG_QUORUM: cfg_q.quorum    <= cfg_data[VOTE_BITS-1:0];
				CFG_STEP:   cfg_q.step      <= cfg_data;
				default: ;
			endcase
		end
	end

	// last-sequence table
	qrs_seq_mem #(
		.DEPTH (NUM_PROCS),
		.WIDTH (SEQ_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer; busy keeps a new read away from a pending write-back
	qrs_engine #(
		.NUM_PROCS (NUM_PROCS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// an accepted word always raises busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// results never come in consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe in two consecutive cycles");

	// the vote count reloads before it can be seen at zero
	a_votes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.remaining != '0))
		else $error("remaining votes reported as zero");

	// a finished round needs a vote from this completion
	a_round_needs_vote: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.round_done) |-> (result.counted && !result.failed && !result.ignored))
		else $error("round completed without a counted vote");

endmodule

`default_nettype wire

FILE: tb/tb_quorum_round_scoreboard_top.sv
// Self-checking bench for quorum_round_scoreboard_top: sequence table, vote and round tracking.
// Depends on qrs_pkg and the block's RTL; a tracker class predicts every result word.
`timescale 1ns / 1ps

module tb_quorum_round_scoreboard_top;
	import qrs_pkg::*;

	// kind code the block leaves unused
	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
	localparam int N_PHASES        = 6;
	localparam int WORDS_PER_PHASE = 72;

	// shadow of the block: sequence table, round, votes and registers
	class qrs_vote_tracker;
		logic [SEQ_BITS-1:0]   seq_entry [NUM_PROCS_DEF];
		logic [SEQ_BITS-1:0]   round;
		logic [VOTE_BITS-1:0]  votes;
		logic [CLASS_BITS-1:0] want_class;
		logic [VOTE_BITS-1:0]  quorum;
		logic [SEQ_BITS-1:0]   step;
		qrs_result_t           pending_results [$];
		int                    mismatches;
		int                    words_by_kind [4];
		int                    votes_seen;
		int                    rounds_closed;
		int                    results_seen;

		function new();
			foreach (seq_entry[i]) seq_entry[i] = '0;
			round = '0;
			votes = 5'd1;
			want_class = '0;
			quorum = 5'd1;
			step = 48'd1;
			mismatches = 0;
			foreach (words_by_kind[i]) words_by_kind[i] = 0;
			votes_seen = 0;
			rounds_closed = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [STEP_BITS-1:0] data);
			case (idx)
				CFG_CLASS:  want_class = data[CLASS_BITS-1:0];
				CFG_QUORUM: quorum = data[VOTE_BITS-1:0];
				CFG_STEP:   step = {{(SEQ_BITS-STEP_BITS){1'b0}}, data};
				default: ;
			endcase
		endfunction

		// entry one step behind the round: its next in-order completion votes
		function bit is_ready(int p);
			logic [SEQ_BITS-1:0] nxt;
			nxt = seq_entry[p] + step;
			return nxt == round;
		endfunction

		// work out the result of one accepted word and queue it
		function void accept_word(qrs_item_t w);
			qrs_result_t         r;
			logic [SEQ_BITS-1:0] nxt;
			int                  cnt;
			r = '0;
			cnt = 0;
			words_by_kind[w.kind]++;
			case (w.kind)
				KIND_CMPL: begin
					if (!w.ok)
						r.failed = 1'b1;
					else if (w.msg_class != want_class || w.process >= NUM_PROCS_DEF)
						r.ignored = 1'b1;
					else begin
						nxt = seq_entry[w.process] + step;
						seq_entry[w.process] = (nxt == w.seq) ? w.seq : '0;
						if (seq_entry[w.process] == round) begin
							votes = votes - 5'd1;
							r.counted = 1'b1;
							r.hit_process = w.process;
							votes_seen++;
						end
						// quorum reached: reload (never from zero) and move the round on
						if (votes == '0) begin
							votes = (quorum == '0) ? 5'd1 : quorum;
							round = round + step;
							r.round_done = 1'b1;
							rounds_closed++;
						end
					end
				end
				KIND_RESTART: begin
					if (w.restart_id == '0)
						r.restart_rejected = 1'b1;
					else begin
						foreach (seq_entry[i]) seq_entry[i] = w.restart_id - step;
						round = w.restart_id;
					end
				end
				KIND_QUERY: begin
					foreach (seq_entry[i]) if (is_ready(i)) cnt++;
					r.ready_count = (cnt > 31) ? 5'd31 : cnt[VOTE_BITS-1:0];
				end
				default: ;
			endcase
			r.remaining = votes;
			r.round_id = round;
			pending_results = {pending_results, r};
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		// compare a result word with the oldest expectation
		function void check_word(qrs_result_t got);
			qrs_result_t want;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			check_field("failed", want.failed, got.failed);
			check_field("ignored", want.ignored, got.ignored);
			check_field("counted", want.counted, got.counted);
			check_field("hit_process", want.hit_process, got.hit_process);
			check_field("remaining", want.remaining, got.remaining);
			check_field("round_done", want.round_done, got.round_done);
			check_field("round_id", want.round_id, got.round_id);
			check_field("ready_count", want.ready_count, got.ready_count);
			check_field("restart_rejected", want.restart_rejected, got.restart_rejected);
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [STEP_BITS-1:0]    cfg_data = '0;
	logic                    start = 1'b0;
	qrs_item_t               item = '0;
	logic                    busy;
	logic                    done;
	qrs_result_t             result;

	qrs_vote_tracker sb;

	quorum_round_scoreboard_top #(
		.NUM_PROCS(NUM_PROCS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// results cannot be held off: take every strobed word
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_word(result);
	end

	function automatic logic [SEQ_BITS-1:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[SEQ_BITS-1:0];
	endfunction

	function automatic qrs_item_t mk(logic [KIND_BITS-1:0] k, logic ok, logic [CLASS_BITS-1:0] c,
			logic [PROC_BITS-1:0] p, logic [SEQ_BITS-1:0] s, logic [SEQ_BITS-1:0] rid);
		qrs_item_t w;
		w.kind = k;
		w.ok = ok;
		w.msg_class = c;
		w.process = p;
		w.seq = s;
		w.restart_id = rid;
		return w;
	endfunction

	// random word, mostly in-order completions that push the rounds along
	function automatic qrs_item_t pick_word();
		qrs_item_t w;
		int        roll;
		int        ready [$];
		int        p;
		w = mk(KIND_CMPL, 1'b1, sb.want_class, PROC_BITS'($urandom_range(0, NUM_PROCS_DEF - 1)),
			rand48(), rand48());
		roll = $urandom_range(0, 99);
		if (roll < 62) begin
			for (int i = 0; i < NUM_PROCS_DEF; i++) if (sb.is_ready(i)) ready = {ready, i};
			if (ready.size() > 0 && $urandom_range(0, 2) != 0)
				p = ready[$urandom_range(0, ready.size() - 1)];
			else
				p = w.process;
			w.process = PROC_BITS'(p);
			w.seq = sb.seq_entry[p] + sb.step;
		end else if (roll < 70) begin
			// out of order: entry drops to zero
		end else if (roll < 75) begin
			w.ok = 1'b0;
			w.msg_class = CLASS_BITS'($urandom);
		end else if (roll < 80) begin
			w.msg_class = sb.want_class ^ CLASS_BITS'($urandom_range(1, 7));
		end else begin
			w.ok = 1'($urandom);
			w.msg_class = CLASS_BITS'($urandom);
			if (roll < 88)
				w.kind = KIND_QUERY;
			else if (roll < 96) begin
				w.kind = KIND_RESTART;
				if (w.restart_id == '0) w.restart_id = 48'd1;
			end else if (roll < 98) begin
				w.kind = KIND_RESTART;
				w.restart_id = '0;
			end else
				w.kind = KIND_UNUSED;
		end
		return w;
	endfunction

	// offer one word and hold it until the block takes it
	task automatic send_word(qrs_item_t w);
		item <= w;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.accept_word(w);
	endtask

	// stop sending and wait until the block has answered everything
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0 || busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_settings(logic [CLASS_BITS-1:0] c, logic [VOTE_BITS-1:0] q,
			logic [STEP_BITS-1:0] s);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLASS;
		cfg_data <= STEP_BITS'(c);
		@(posedge clk);
		sb.set_reg(CFG_CLASS, STEP_BITS'(c));
		cfg_index <= CFG_QUORUM;
		cfg_data <= STEP_BITS'(q);
		@(posedge clk);
		sb.set_reg(CFG_QUORUM, STEP_BITS'(q));
		cfg_index <= CFG_STEP;
		cfg_data <= s;
		@(posedge clk);
		sb.set_reg(CFG_STEP, s);
		cfg_we <= 1'b0;
	endtask

	// directed words under the reset register values
	task automatic run_directed();
		localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;
		// table is unknown until the first restart
		send_word(mk(KIND_RESTART, 1'b0, 3'd0, 4'd0, '0, 48'd1));
		send_word(mk(KIND_QUERY, 1'b0, 3'd0, 4'd0, '0, '0));
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd0, 48'd1, '0));
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd15, 48'd1, '0));
		// out-of-order sequence clears the entry
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd15, 48'd5, '0));
		send_word(mk(KIND_CMPL, 1'b0, 3'd7, 4'd3, SEQ_MAX, SEQ_MAX));
		send_word(mk(KIND_CMPL, 1'b1, 3'd7, 4'd3, '0, '0));
		send_word(mk(KIND_UNUSED, 1'b1, 3'd7, 4'd15, SEQ_MAX, SEQ_MAX));
		send_word(mk(KIND_RESTART, 1'b1, 3'd7, 4'd15, SEQ_MAX, '0));
		// round id at the top of the range, then wrap to zero
		send_word(mk(KIND_RESTART, 1'b0, 3'd0, 4'd0, '0, SEQ_MAX));
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd5, SEQ_MAX, '0));
		send_word(mk(KIND_QUERY, 1'b0, 3'd0, 4'd0, '0, '0));
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd6, SEQ_MAX, '0));
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd6, '0, '0));
		send_word(mk(KIND_RESTART, 1'b0, 3'd0, 4'd0, '0, 48'h8000_0000_0000));
		send_word(mk(KIND_QUERY, 1'b1, 3'd7, 4'd15, SEQ_MAX, SEQ_MAX));
		send_word(mk(KIND_CMPL, 1'b1, 3'd0, 4'd10, 48'h8000_0000_0000, '0));
		send_word(mk(KIND_QUERY, 1'b0, 3'd0, 4'd0, '0, '0));
	endtask

	initial begin
		#2_000_000;
		$display("tb_quorum_round_scoreboard_top: errors");
		$finish;
	end

	initial begin
		logic [CLASS_BITS-1:0] ph_class [N_PHASES];
		logic [VOTE_BITS-1:0]  ph_quorum [N_PHASES];
		logic [STEP_BITS-1:0]  ph_step [N_PHASES];
		int                    burst_left;
		int                    gap;
		bit                    hold_off;
		logic [SEQ_BITS-1:0]   rid;

		ph_class  = '{3'd7, 3'd2, 3'd5, 3'd0, 3'd6, 3'd1};
		ph_quorum = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd2};
		ph_step   = '{16'hFFFF, 16'd1, 16'd0, 16'd7, 16'd1000, 16'h8001};
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_settings(ph_class[ph], ph_quorum[ph], ph_step[ph]);
			rid = rand48();
			if (rid == '0) rid = 48'd1;
			send_word(mk(KIND_RESTART, 1'b1, ph_class[ph], 4'd0, '0, rid));
			burst_left = 0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// bursts with gaps; phase 1 runs back to back unless a hold-off forces a gap
				if (burst_left == 0) begin
					gap = (ph == 1) ? 0 : $urandom_range(0, 6);
					hold_off = ($urandom_range(0, 7) == 0);
					if (hold_off && gap == 0) gap = 1;
					if (gap > 0) begin
						start <= 1'b0;
						repeat (gap) @(posedge clk);
						if (hold_off)
							while (sb.pending_results.size() != 0) @(posedge clk);
					end
					burst_left = $urandom_range(1, 12);
				end
				send_word(pick_word());
				burst_left--;
			end
			drain();
		end

		repeat (NUM_PROCS_DEF + 8) @(posedge clk);
		$display("covered %0d completions, %0d restarts, %0d count queries, %0d unused-kind words",
			sb.words_by_kind[KIND_CMPL], sb.words_by_kind[KIND_RESTART],
			sb.words_by_kind[KIND_QUERY], sb.words_by_kind[KIND_UNUSED]);
		$display("%0d result words checked: %0d votes, %0d rounds closed, %0d register settings",
			sb.results_seen, sb.votes_seen, sb.rounds_closed, N_PHASES + 1);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb_quorum_round_scoreboard_top: clean");
		else
			$display("tb_quorum_round_scoreboard_top: errors");
		$finish;
	end

endmodule

FILE: sim.f
src/qrs_pkg.sv
src/qrs_seq_mem.sv
src/qrs_engine.sv
src/quorum_round_scoreboard_top.sv
tb/tb_quorum_round_scoreboard_top.sv
